>>> hw/rtl/tsd_pkg.sv
package tsd_pkg;

    // delta unit selector
    localparam logic [1:0] UNIT_SEC = 2'd0;
    localparam logic [1:0] UNIT_MS  = 2'd1;
    localparam logic [1:0] UNIT_US  = 2'd2;
    localparam logic [1:0] UNIT_NS  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [31:0] NS_MAX_VALID = 32'd999999999;
    localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;

    // units per second, as a multiplier of whole seconds
    localparam logic [29:0] SEC_TO_MS = 30'd1000;
    localparam logic [29:0] SEC_TO_US = 30'd1000000;
    localparam logic [29:0] SEC_TO_NS = 30'd1000000000;

    // floor(x / 1e6) = (x * RECIP_MS) >> 50 and floor(x / 1e3) = (x * RECIP_US) >> 40
    // for every x below 1e9
    localparam logic [30:0] RECIP_MS = 31'd1125899907;
    localparam logic [30:0] RECIP_US = 31'd1099511628;
    localparam int          SHIFT_MS = 50;
    localparam int          SHIFT_US = 40;

    // largest (seconds, nanoseconds) gap whose floored delta still fits 32 bits
    localparam logic [31:0] LIM_MS_SEC = 32'd4294967;
    localparam logic [29:0] LIM_MS_NS  = 30'd295999999;
    localparam logic [31:0] LIM_US_SEC = 32'd4294;
    localparam logic [29:0] LIM_US_NS  = 30'd967295999;
    localparam logic [31:0] LIM_NS_SEC = 32'd4;
    localparam logic [29:0] LIM_NS_NS  = 30'd294967295;

    // gap between the two timestamps, after compare and subtract
    typedef struct packed {
        logic [1:0]  unit;
        logic        invalid;
        logic        first_less;
        logic        both_equal;
        logic        first_greater;
        logic [31:0] dsec;
        logic [29:0] dns;
    } gap_t;

endpackage

>>> hw/rtl/tsd_scale.sv
module tsd_scale
    import tsd_pkg::*;
(
    input  gap_t        gap,
    output logic [31:0] delta,
    output logic [1:0]  status
);

    logic [30:0] recip;
    logic [60:0] frac_prod;
    logic [29:0] frac_q;
    logic [29:0] sec_scale;
    logic [61:0] int_prod;
    logic        overflow;
    logic [31:0] sum;

    always_comb begin
        recip     = RECIP_US;
        sec_scale = 30'd1;
        overflow  = 1'b0;
        if (gap.unit == UNIT_MS) begin
            recip = RECIP_MS;
        end
        unique case (gap.unit)
            UNIT_SEC: begin
                sec_scale = 30'd1;
            end
            UNIT_MS: begin
                sec_scale = SEC_TO_MS;
                overflow  = (gap.dsec > LIM_MS_SEC) ||
                            ((gap.dsec == LIM_MS_SEC) && (gap.dns > LIM_MS_NS));
            end
            UNIT_US: begin
                sec_scale = SEC_TO_US;
                overflow  = (gap.dsec > LIM_US_SEC) ||
                            ((gap.dsec == LIM_US_SEC) && (gap.dns > LIM_US_NS));
            end
            UNIT_NS: begin
                sec_scale = SEC_TO_NS;
                overflow  = (gap.dsec > LIM_NS_SEC) ||
                            ((gap.dsec == LIM_NS_SEC) && (gap.dns > LIM_NS_NS));
            end
            default: begin
                sec_scale = 30'd1;
            end
        endcase
    end

    assign frac_prod = {31'd0, gap.dns} * {30'd0, recip};
    assign int_prod  = {30'd0, gap.dsec} * {32'd0, sec_scale};

    always_comb begin
        case (gap.unit)
            UNIT_MS: frac_q = {20'd0, frac_prod[SHIFT_MS +: 10]};
            UNIT_US: frac_q = {10'd0, frac_prod[SHIFT_US +: 20]};
            UNIT_NS: frac_q = gap.dns;
            default: frac_q = 30'd0;
        endcase
    end

    // only the low word matters once the true value is known to fit
    assign sum = int_prod[31:0] + {2'd0, frac_q};

    always_comb begin
        if (gap.invalid) begin
            status = ST_INVALID;
            delta  = 32'd0;
        end else if (overflow) begin
            status = ST_OVERFLOW;
            delta  = 32'd0;
        end else begin
            status = ST_OK;
            delta  = sum;
        end
    end

endmodule

>>> hw/rtl/timestamp_difference_compare_top.sv
// Channel | Ports               | Contents
// input   | s_tvalid/s_tready   | s_tdata: two seconds+ns timestamps, s_tuser: delta unit
// result  | m_tvalid/m_tready   | m_tdata: delta, status, ordering flags
//
// One transaction accepted per cycle unless a stall on m_tready fills every stage;
// a result passes the input, compare/subtract and result registers in turn.
// The multiply-and-add scaling stage sets the critical path.
// aresetn clears the stage valid bits only; data registers are not reset.
// A stall on m_tready holds the result; upstream stages keep filling bubbles.
module timestamp_difference_compare_top
    import tsd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] first_seconds, [63:32] first_nanoseconds,
    // [95:64] second_seconds, [127:96] second_nanoseconds
    input  logic [127:0] s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] delta, [33:32] status, [34] first_less, [35] both_equal,
    // [36] first_greater, [39:37] zero
    output logic [39:0]  m_tdata
);

    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] fs_reg, fns_reg, ss_reg, sns_reg;
    logic        gap_valid_reg;
    gap_t        gap_reg;
    gap_t        gap_next;
    logic        out_valid_reg;
    logic [31:0] delta_reg;
    logic [1:0]  status_reg;
    logic        lt_reg, eq_reg, gt_reg;
    logic [31:0] delta_next;
    logic [1:0]  status_next;

    logic adv_out, adv_gap, adv_in;

    assign adv_out  = !out_valid_reg || m_tready;
    assign adv_gap  = !gap_valid_reg || adv_out;
    assign adv_in   = !in_valid_reg || adv_gap;
    assign s_tready = adv_in;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            gap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_in) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv_gap) begin
                gap_valid_reg <= in_valid_reg;
            end
            if (adv_out) begin
                out_valid_reg <= gap_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            cmd_reg <= s_tuser;
            fs_reg  <= s_tdata[31:0];
            fns_reg <= s_tdata[63:32];
            ss_reg  <= s_tdata[95:64];
            sns_reg <= s_tdata[127:96];
        end
    end

    // compare and subtract, larger minus smaller
    logic        sec_lt, sec_eq, lt, eq, invalid, borrow;
    logic [31:0] hi_s, lo_s, hi_ns, lo_ns, ns_diff;

    always_comb begin
        invalid = (fns_reg > NS_MAX_VALID) || (sns_reg > NS_MAX_VALID);
        sec_lt  = fs_reg < ss_reg;
        sec_eq  = fs_reg == ss_reg;
        lt      = sec_lt || (sec_eq && (fns_reg < sns_reg));
        eq      = sec_eq && (fns_reg == sns_reg);
        hi_s    = lt ? ss_reg  : fs_reg;
        lo_s    = lt ? fs_reg  : ss_reg;
        hi_ns   = lt ? sns_reg : fns_reg;
        lo_ns   = lt ? fns_reg : sns_reg;
        borrow  = hi_ns < lo_ns;
        ns_diff = borrow ? (hi_ns + NS_PER_SEC - lo_ns) : (hi_ns - lo_ns);

        gap_next.unit          = cmd_reg;
        gap_next.invalid       = invalid;
        gap_next.first_less    = !invalid && lt;
        gap_next.both_equal    = !invalid && eq;
        gap_next.first_greater = !invalid && !lt && !eq;
        gap_next.dsec          = hi_s - lo_s - {31'd0, borrow};
        gap_next.dns           = ns_diff[29:0];
    end

    always_ff @(posedge aclk) begin
        if (adv_gap) begin
            gap_reg <= gap_next;
        end
    end

    tsd_scale u_scale (
        .gap    (gap_reg),
        .delta  (delta_next),
        .status (status_next)
    );

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            delta_reg  <= delta_next;
            status_reg <= status_next;
            lt_reg     <= gap_reg.first_less;
            eq_reg     <= gap_reg.both_equal;
            gt_reg     <= gap_reg.first_greater;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, gt_reg, eq_reg, lt_reg, status_reg, delta_reg};

endmodule

>>> hw/rtl/tsd_checker.sv
module tsd_checker
    import tsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // invalid input gives zero delta and clear flags
    a_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == ST_INVALID) |-> (m_tdata[31:0] == 32'd0) &&
        (m_tdata[36:34] == 3'd0))
        else $error("invalid result not cleared");

    // valid input gives exactly one ordering flag, and a status code in range
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != ST_INVALID) |-> $onehot(m_tdata[36:34]) &&
        ((m_tdata[33:32] == ST_OK) || (m_tdata[33:32] == ST_OVERFLOW)))
        else $error("bad ordering flags or status");

    // overflow reports zero delta
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == ST_OVERFLOW) |-> (m_tdata[31:0] == 32'd0))
        else $error("overflow delta not zero");

endmodule

bind timestamp_difference_compare_top tsd_checker u_tsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
